### hdl/segment_intersection_defines.svh
// assertion macros for the segment intersection block
// used by the port checker, which provides i_clk and i_rst_n in its scope
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/segint_pkg.sv
// shared types and constants of the segment intersection block
// no dependencies; used by the top level and the port checker
`default_nettype none

package segint_pkg;

    localparam int FIELD_W       = 16;  // width of each coordinate port
    localparam int CFG_W         = 33;  // width of the parallel threshold
    localparam int POINT_W       = 24;  // width of each result coordinate
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [CFG_W-1:0] THRESH_RESET = CFG_W'(1);

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef struct packed {
        logic                       hit;
        t_status                    status;
        logic signed [POINT_W-1:0]  point_x;
        logic signed [POINT_W-1:0]  point_y;
    } t_result;

endpackage

`default_nettype wire

### hdl/segint_div.sv
// pipelined restoring divider, one quotient bit per register stage
// no package dependencies; instantiated by segment_intersection
`default_nettype none

module segint_div #(
    parameter int DW = 35,  // divisor and partial remainder width
    parameter int QW = 24   // quotient width
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [DW+QW-1:0]   i_num,
    input  wire logic [DW-1:0]      i_den,
    output logic      [QW-1:0]      o_quo,
    output logic                    o_rem_nz
);

    // the top DW bits of the dividend must already be below the divisor
    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_lq  [QW];   // dividend bits still to shift in, quotient bits behind

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] lq_in;
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = i_num[DW+QW-1:QW];
            assign lq_in  = i_num[QW-1:0];
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign lq_in  = r_lq[k-1];
            assign den_in = r_den[k-1];
        end

        assign trial = {rem_in, lq_in[QW-1]};
        assign diff  = {1'b0, trial} - {2'b00, den_in};
        assign ge    = ~diff[DW+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_lq[k]  <= {lq_in[QW-2:0], ge};
            end
        end

        if (k < QW - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo    = r_lq[QW-1];
    assign o_rem_nz = |r_rem[QW-1];

endmodule

`default_nettype wire

### hdl/segment_intersection.sv
// top level of the 2d segment intersection pipeline
// depends on segint_pkg and segint_div
`default_nettype none

// Tests segment AB against segment CD and, when they meet, returns the crossing point
// A + t*(B-A) in fixed point with FRAC_BITS fraction bits, each coordinate rounded toward
// negative infinity. The cross product of the two directions is compared with the
// parallel_threshold register (reset 1, written through the cfg channel; the user must
// write it only while the block is idle, which the block does not enforce); a zero cross
// product always reports parallel. The block is fully pipelined: while o_stall is low,
// one item is accepted per clock, and while i_stall is low one result leaves per clock.
// There are five stages of difference, multiply, cross, sign-normalize and bound test,
// then one stage per quotient bit in the two point dividers (COORD_BITS + FRAC_BITS of
// them, with COORD_BITS taken as at most 17), then the output register. A one-item skid
// buffer sits behind the output register, so o_stall is registered and only rises after a
// result has been held at a stalled output; items keep flowing in while a result waits.
module segment_intersection #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    // input items
    input  wire logic                                       i_valid,
    output logic                                            o_stall,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_a_x,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_a_y,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_b_x,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_b_y,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_c_x,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_c_y,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_d_x,
    input  wire logic signed [segint_pkg::FIELD_W-1:0]      i_d_y,
    // threshold write channel
    input  wire logic                                       i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  wire logic [segint_pkg::CFG_W-1:0]               i_cfg_data,
    // result items
    output logic                                            o_valid,
    input  wire logic                                       i_stall,
    output logic                                            o_hit,
    output logic [1:0]                                      o_status,
    output logic signed [segint_pkg::POINT_W-1:0]           o_point_x,
    output logic signed [segint_pkg::POINT_W-1:0]           o_point_y
);

    localparam int FW   = segint_pkg::FIELD_W;
    // coordinates wider than the port are never negative: one extra zero bit covers them
    localparam int CW   = (COORD_BITS > FW) ? FW + 1 : COORD_BITS;
    localparam int LSH  = (COORD_BITS < FW) ? FW - COORD_BITS : 0;
    localparam int DFW  = CW + 1;             // coordinate differences
    localparam int PRW  = 2 * CW + 2;         // partial products
    localparam int XW   = 2 * CW + 3;         // cross products
    localparam int MW   = XW + CW;            // tn * |direction|
    localparam int QW   = CW + FRAC_BITS;     // quotient bits, one divider stage each
    localparam int PW   = CW + FRAC_BITS + 2; // exact point width
    localparam int CMPW = (XW > segint_pkg::CFG_W) ? XW : segint_pkg::CFG_W;

    typedef struct packed {
        logic                   hit;
        segint_pkg::t_status    status;
        logic signed [CW-1:0]   ax;
        logic signed [CW-1:0]   ay;
        logic                   xneg;
        logic                   yneg;
    } t_side;

    // ------------------------------------------------------------------
    // flow control: the whole pipe advances unless the skid slot is full
    // ------------------------------------------------------------------
    logic                       r_skid_v;
    logic                       r_out_v;
    logic                       w_en;
    logic                       w_out_take;

    assign w_en       = ~r_skid_v;
    assign w_out_take = r_out_v & ~i_stall;
    assign o_stall    = r_skid_v;

    // threshold register, always ready
    logic [segint_pkg::CFG_W-1:0] r_thr;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // coordinate decode: if COORD_BITS <= FIELD_W, low COORD_BITS bits as two's complement
    // ------------------------------------------------------------------
    logic [FW-1:0]          w_raw [8];
    logic signed [CW-1:0]   w_crd [8];

    always_comb begin
        logic signed [FW-1:0] sx;
        w_raw[0] = i_a_x;
        w_raw[1] = i_a_y;
        w_raw[2] = i_b_x;
        w_raw[3] = i_b_y;
        w_raw[4] = i_c_x;
        w_raw[5] = i_c_y;
        w_raw[6] = i_d_x;
        w_raw[7] = i_d_y;
        for (int k = 0; k < 8; k++) begin
            sx = $signed(w_raw[k] << LSH) >>> LSH;
            if (COORD_BITS > FW) begin
                w_crd[k] = CW'({1'b0, w_raw[k]});
            end else begin
                w_crd[k] = CW'(sx);
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    // stage a: direction and offset vectors
    logic                   r_va;
    logic signed [CW-1:0]   r_a_ax, r_a_ay;
    logic signed [DFW-1:0]  r_a_rx, r_a_ry, r_a_sx, r_a_sy, r_a_cax, r_a_cay;
    // stage b: six products
    logic                   r_vb;
    logic signed [CW-1:0]   r_b_ax, r_b_ay;
    logic signed [DFW-1:0]  r_b_rx, r_b_ry;
    logic signed [PRW-1:0]  r_b_p [6];
    // stage c: den, sn, tn
    logic                   r_vc;
    logic signed [CW-1:0]   r_c_ax, r_c_ay;
    logic signed [DFW-1:0]  r_c_rx, r_c_ry;
    logic signed [XW-1:0]   r_c_den, r_c_sn, r_c_tn;
    // stage d: sign-normalized so that den is never negative
    logic                   r_vd;
    logic signed [CW-1:0]   r_d_ax, r_d_ay;
    logic [CW-1:0]          r_d_rxa, r_d_rya;
    logic                   r_d_xneg, r_d_yneg;
    logic signed [XW-1:0]   r_d_den, r_d_sn, r_d_tn;
    // stage e: classified, numerators for the point dividers
    logic                   r_ve;
    t_side                  r_e_side;
    logic [MW-1:0]          r_e_mx, r_e_my;
    logic [XW-1:0]          r_e_den;
    // side data riding along the dividers
    logic                   r_dv   [QW];
    t_side                  r_side [QW];
    // output register and skid slot, fed by the finished result
    segint_pkg::t_result    r_out, r_skid;
    segint_pkg::t_result    n_res;

    // ------------------------------------------------------------------
    // stage e classification
    // ------------------------------------------------------------------
    logic                   w_par, w_outside;
    t_side                  w_e_side;

    always_comb begin
        w_par = (r_d_den == '0)
              || (CMPW'($unsigned(r_d_den)) < CMPW'(r_thr));
        w_outside = r_d_sn[XW-1] || r_d_tn[XW-1]
                  || (r_d_sn > r_d_den) || (r_d_tn > r_d_den);
        w_e_side.ax   = r_d_ax;
        w_e_side.ay   = r_d_ay;
        w_e_side.xneg = r_d_xneg;
        w_e_side.yneg = r_d_yneg;
        // parallel wins over the bound test
        priority if (w_par) begin
            w_e_side.hit    = 1'b0;
            w_e_side.status = segint_pkg::ST_PARALLEL;
        end else if (w_outside) begin
            w_e_side.hit    = 1'b0;
            w_e_side.status = segint_pkg::ST_OUTSIDE;
        end else begin
            w_e_side.hit    = 1'b1;
            w_e_side.status = segint_pkg::ST_HIT;
        end
    end

    // ------------------------------------------------------------------
    // control registers: valid bits, threshold, output occupancy
    // ------------------------------------------------------------------
    logic n_out_v, n_skid_v;
    logic w_load_out, w_load_skid, w_from_skid;
    logic w_last_v;

    assign w_last_v = r_dv[QW-1];

    always_comb begin
        n_out_v     = r_out_v;
        n_skid_v    = r_skid_v;
        w_load_out  = 1'b0;
        w_load_skid = 1'b0;
        w_from_skid = 1'b0;
        if (w_en) begin
            if (w_last_v) begin
                // a new result goes to the output unless the output is held
                if (!r_out_v || w_out_take) begin
                    w_load_out = 1'b1;
                    n_out_v    = 1'b1;
                end else begin
                    w_load_skid = 1'b1;
                    n_skid_v    = 1'b1;
                end
            end else if (w_out_take) begin
                n_out_v = 1'b0;
            end
        end else if (w_out_take) begin
            // pipe frozen: drain the skid slot into the output register
            w_from_skid = 1'b1;
            n_skid_v    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va     <= 1'b0;
            r_vb     <= 1'b0;
            r_vc     <= 1'b0;
            r_vd     <= 1'b0;
            r_ve     <= 1'b0;
            r_dv     <= '{default: 1'b0};
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
            r_thr    <= segint_pkg::THRESH_RESET;
        end else begin
            if (w_en) begin
                r_va  <= i_valid;
                r_vb  <= r_va;
                r_vc  <= r_vb;
                r_vd  <= r_vc;
                r_ve  <= r_vd;
                r_dv[0] <= r_ve;
                for (int k = 1; k < QW; k++) begin
                    r_dv[k] <= r_dv[k-1];
                end
            end
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage a
            r_a_ax  <= w_crd[0];
            r_a_ay  <= w_crd[1];
            r_a_rx  <= DFW'(w_crd[2]) - DFW'(w_crd[0]);
            r_a_ry  <= DFW'(w_crd[3]) - DFW'(w_crd[1]);
            r_a_sx  <= DFW'(w_crd[6]) - DFW'(w_crd[4]);
            r_a_sy  <= DFW'(w_crd[7]) - DFW'(w_crd[5]);
            r_a_cax <= DFW'(w_crd[0]) - DFW'(w_crd[4]);
            r_a_cay <= DFW'(w_crd[1]) - DFW'(w_crd[5]);
            // stage b
            r_b_ax   <= r_a_ax;
            r_b_ay   <= r_a_ay;
            r_b_rx   <= r_a_rx;
            r_b_ry   <= r_a_ry;
            r_b_p[0] <= PRW'(r_a_rx) * PRW'(r_a_sy);
            r_b_p[1] <= PRW'(r_a_ry) * PRW'(r_a_sx);
            r_b_p[2] <= PRW'(r_a_rx) * PRW'(r_a_cay);
            r_b_p[3] <= PRW'(r_a_ry) * PRW'(r_a_cax);
            r_b_p[4] <= PRW'(r_a_sx) * PRW'(r_a_cay);
            r_b_p[5] <= PRW'(r_a_sy) * PRW'(r_a_cax);
            // stage c: den = r x s, sn = r x ca, tn = s x ca
            r_c_ax  <= r_b_ax;
            r_c_ay  <= r_b_ay;
            r_c_rx  <= r_b_rx;
            r_c_ry  <= r_b_ry;
            r_c_den <= XW'(r_b_p[0]) - XW'(r_b_p[1]);
            r_c_sn  <= XW'(r_b_p[2]) - XW'(r_b_p[3]);
            r_c_tn  <= XW'(r_b_p[4]) - XW'(r_b_p[5]);
            // stage d: flip all three when den is negative
            r_d_ax   <= r_c_ax;
            r_d_ay   <= r_c_ay;
            r_d_xneg <= r_c_rx[DFW-1];
            r_d_yneg <= r_c_ry[DFW-1];
            r_d_rxa  <= CW'(r_c_rx[DFW-1] ? -r_c_rx : r_c_rx);
            r_d_rya  <= CW'(r_c_ry[DFW-1] ? -r_c_ry : r_c_ry);
            r_d_den  <= r_c_den[XW-1] ? -r_c_den : r_c_den;
            r_d_sn   <= r_c_den[XW-1] ? -r_c_sn  : r_c_sn;
            r_d_tn   <= r_c_den[XW-1] ? -r_c_tn  : r_c_tn;
            // stage e: tn * |r| feeds floor(tn * r * 2^F / den)
            r_e_side <= w_e_side;
            r_e_den  <= $unsigned(r_d_den);
            r_e_mx   <= MW'($unsigned(r_d_tn)) * MW'(r_d_rxa);
            r_e_my   <= MW'($unsigned(r_d_tn)) * MW'(r_d_rya);
            // side data travels with the divider stages
            r_side[0] <= r_e_side;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_load_out) begin
            r_out <= n_res;
        end else if (w_from_skid) begin
            r_out <= r_skid;
        end
        if (w_load_skid) begin
            r_skid <= n_res;
        end
    end

    // ------------------------------------------------------------------
    // point dividers, one per coordinate
    // ------------------------------------------------------------------
    logic [QW-1:0] w_qx, w_qy;
    logic          w_nzx, w_nzy;

    segint_div #(
        .DW (XW),
        .QW (QW)
    ) u_div_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    ((XW + QW)'(r_e_mx) << FRAC_BITS),
        .i_den    (r_e_den),
        .o_quo    (w_qx),
        .o_rem_nz (w_nzx)
    );

    segint_div #(
        .DW (XW),
        .QW (QW)
    ) u_div_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    ((XW + QW)'(r_e_my) << FRAC_BITS),
        .i_den    (r_e_den),
        .o_quo    (w_qy),
        .o_rem_nz (w_nzy)
    );

    // base * 2^F plus the floored offset; a negative direction needs
    // -ceil(q) = -(quo + (rem != 0)), folded into one add as ~quo + !nz
    function automatic logic signed [PW-1:0] f_place(
        input logic signed [CW-1:0] base,
        input logic [QW-1:0]        quo,
        input logic                 rem_nz,
        input logic                 neg
    );
        logic signed [PW-1:0] b;
        logic [PW-1:0]        q;
        logic [PW-1:0]        off;
        b   = PW'(base) <<< FRAC_BITS;
        q   = PW'(quo);
        off = neg ? (~q + PW'(!rem_nz)) : q;
        return b + $signed(off);
    endfunction

    logic signed [PW-1:0]   w_px, w_py;
    t_side                  w_last;

    always_comb begin
        w_last        = r_side[QW-1];
        w_px          = f_place(w_last.ax, w_qx, w_nzx, w_last.xneg);
        w_py          = f_place(w_last.ay, w_qy, w_nzy, w_last.yneg);
        n_res.hit     = w_last.hit;
        n_res.status  = w_last.status;
        n_res.point_x = w_last.hit ? segint_pkg::POINT_W'(w_px) : '0;
        n_res.point_y = w_last.hit ? segint_pkg::POINT_W'(w_py) : '0;
    end

    // ------------------------------------------------------------------
    // result ports
    // ------------------------------------------------------------------
    assign o_valid   = r_out_v;
    assign o_hit     = r_out.hit;
    assign o_status  = r_out.status;
    assign o_point_x = r_out.point_x;
    assign o_point_y = r_out.point_y;

endmodule

`default_nettype wire

### hdl/segint_checker.sv
// port-level checker for the segment intersection block, bound to the top level
// depends on segint_pkg and segment_intersection_defines.svh
`default_nettype none
`include "segment_intersection_defines.svh"

module segint_checker (
    input wire logic                                    i_clk,
    input wire logic                                    i_rst_n,
    input wire logic                                    o_stall,
    input wire logic                                    o_valid,
    input wire logic                                    i_stall,
    input wire logic                                    o_hit,
    input wire logic [1:0]                              o_status,
    input wire logic signed [segint_pkg::POINT_W-1:0]   o_point_x,
    input wire logic signed [segint_pkg::POINT_W-1:0]   o_point_y
);

    // hit flag and status code agree
    `SI_ASSERT_NOW(a_hit_status, o_valid, o_hit == (o_status == segint_pkg::ST_HIT), "hit and status disagree")

    // no point unless hit
    `SI_ASSERT_NOW(a_miss_zero, o_valid && !o_hit, (o_point_x == '0) && (o_point_y == '0), "point not zero on a miss")

    // input stall only comes from a result held at a stalled output
    `SI_ASSERT_NOW(a_stall_cause, $rose(o_stall), $past(o_valid && i_stall), "input stall without output stall")

    // skid slot full means the output register is full too
    `SI_ASSERT_NOW(a_skid_out, o_stall, o_valid, "input stalled with no result waiting")

    // a stalled result keeps its valid flag, x coordinate and status
    `SI_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_point_x) && $stable(o_status), "stalled result changed")

endmodule

bind segment_intersection segint_checker u_segint_checker (.*);

`default_nettype wire
